FILE: rtl/lsac_pkg.sv
`default_nettype none
package lsac_pkg;
  localparam int Sets = 64;
  localparam int Ways = 4;
  localparam int BlockBytes = 64;
  localparam int OffW = $clog2(BlockBytes);
  localparam int SetW = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int SetBits = $clog2(Sets);
  localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int TagW = 32 - OffW - SetBits;
  localparam int QDepth = 2;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR  = 2'd0,
    BK_IDLE   = 2'd1,
    BK_LOOKUP = 2'd2
  } back_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SetW-1:0]   set_idx;
    logic [TagW-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       way;
    logic             evicted;
    logic             victim_dirty;
  } rsp_t;

  typedef struct packed {
    logic [Ways-1:0][TagW-1:0] tags;
    logic [Ways-1:0]           valid;
    logic [Ways-1:0]           dirty;
    logic [Ways-1:0][WayW-1:0] order;
  } set_word_t;

  localparam int SetWordW = $bits(set_word_t);
endpackage
`default_nettype wire

FILE: rtl/lsac_front.sv
`default_nettype none
module lsac_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [1:0]         in_tuser,
  input  wire logic [31:0]        in_tdata,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output lsac_pkg::req_t          q_req
);
  import lsac_pkg::*;

  req_t             buf_r [QDepth];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic             push, pop;
  req_t             req_in;
  logic [31:0]      blk;

  assign blk = in_tdata >> OffW;
  always_comb begin
    req_in.cmd = cmd_t'(in_tuser[0]);
    req_in.set_idx = (Sets > 1) ? SetW'(blk) : '0;
    req_in.tag = TagW'(blk >> SetBits);
  end

  assign in_tready = (cnt_r != 2'(QDepth));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_req = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= req_in;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lsac_back.sv
`default_nettype none
module lsac_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire lsac_pkg::req_t     q_req,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output lsac_pkg::rsp_t          out_rsp
);
  import lsac_pkg::*;

  back_state_t               state_r, state_nxt;
  logic [SetW-1:0]           clr_idx_r, clr_idx_nxt;
  req_t                      req_r;
  set_word_t                 rd_word, wr_word, new_word, reset_word;
  logic                      ram_we;
  logic [SetW-1:0]           ram_waddr;
  logic [Ways-1:0]           match;
  logic                      hit;
  logic [WayW-1:0]           way, pos;
  logic                      take;
  logic                      resolve;
  rsp_t                      rsp_nxt;
  logic                      ov_r, ov_nxt;

  lsac_ram #(
    .Width(SetWordW),
    .Depth(Sets)
  ) u_ram (
    .clk,
    .wr_en(ram_we),
    .wr_addr(ram_waddr),
    .wr_data(wr_word),
    .rd_en(take),
    .rd_addr(q_req.set_idx),
    .rd_data(rd_word)
  );

  always_comb begin
    reset_word = '0;
    for (int i = 0; i < Ways; i++) begin
      reset_word.order[i] = WayW'(i);
    end
  end

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      match[w] = rd_word.valid[w] && (rd_word.tags[w] == req_r.tag);
    end
    hit = |match;
    way = rd_word.order[Ways-1];
    pos = WayW'(Ways-1);
    for (int p = Ways-1; p >= 0; p--) begin
      if (match[rd_word.order[p]]) begin
        way = rd_word.order[p];
        pos = WayW'(p);
      end
    end
    new_word = rd_word;
    for (int p = 1; p < Ways; p++) begin
      if (WayW'(p) <= pos) begin
        new_word.order[p] = rd_word.order[p-1];
      end
    end
    new_word.order[0] = way;
    new_word.valid[way] = 1'b1;
    if (req_r.cmd == CMD_WRITE) begin
      new_word.dirty[way] = 1'b1;
    end else if (!hit) begin
      new_word.dirty[way] = 1'b0;
    end
    if (!hit) begin
      new_word.tags[way] = req_r.tag;
    end
    rsp_nxt.hit = hit;
    rsp_nxt.way = 2'(way);
    rsp_nxt.evicted = !hit && rd_word.valid[way];
    rsp_nxt.victim_dirty = rsp_nxt.evicted && rd_word.dirty[way];
  end

  always_comb begin
    state_nxt = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      BK_CLEAR: begin
        clr_idx_nxt = clr_idx_r + SetW'(1);
        if (clr_idx_r == SetW'(Sets-1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (take) begin
          state_nxt = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = req_r.set_idx;
    wr_word = new_word;
    resolve = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_idx_r;
        wr_word = reset_word;
      end
      BK_IDLE: begin
        q_ready = !ov_r || out_tready;
      end
      BK_LOOKUP: begin
        ram_we = 1'b1;
        resolve = 1'b1;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  assign take = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign ov_nxt = resolve ? 1'b1 : (out_tready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      ov_r <= ov_nxt;
    end
    if (take) begin
      req_r <= q_req;
    end
    if (resolve) begin
      out_rsp <= rsp_nxt;
    end
  end
endmodule

module lsac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [Width-1:0] rd_data
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lru_set_assoc_cache_tags_core.sv
// Channel | Direction | tdata                     | tuser
// in_     | input     | [31:0] address            | [0] command
// out_    | output    | [7:0]: [0] hit, [2:1] way, [3] evicted, [4] victim_dirty, rest zero | -
// A two-entry queue takes accesses; the tag unit reads the set word from RAM in its idle
// state and resolves and writes it back in its lookup state, so it takes a new access
// only after the last one is written back. After reset a clearing pass initialises
// every set before lookups start. A held result stops the tag unit; the queue then
// absorbs up to two accesses.
`default_nettype none
module lru_set_assoc_cache_tags_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // address
  input  wire logic [1:0]  in_tuser,  // command, zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata  // hit, way[1:0], evicted, victim_dirty, zeros
);
  import lsac_pkg::*;

  logic  q_valid, q_ready;
  req_t  q_req;
  rsp_t  rsp;

  lsac_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid, .q_ready, .q_req
  );

  lsac_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_tvalid, .out_tready, .out_rsp(rsp)
  );

  assign out_tdata = {3'b000, rsp.victim_dirty, rsp.evicted, rsp.way, rsp.hit};
endmodule
`default_nettype wire
